// File: design/deap_pkg.sv
// Shared types, codes and constants of the digitizer aggregate parser.
package deap_pkg;

    localparam int CHANNEL_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int WORD_W  = 32;
    localparam int CHAN_W  = 4;
    localparam int PAIR_W  = 19;
    localparam int SAMP_W  = 14;
    localparam int MASK_W  = 16;
    localparam int CNT_W   = 24;
    localparam int SIZE_W  = 28;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 3;
    localparam int CFG_W   = 19;
    localparam int TDATA_W = 144;

    localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NO_TAG     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BOARD_FAIL = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DISABLED   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_SAMPLE = 3'd4;
    localparam logic [ERR_W-1:0] ERR_SIZE       = 3'd5;

    localparam logic REG_ENABLED = 1'b0;
    localparam logic REG_WORDS   = 1'b1;

    localparam logic [WORD_W-1:0] PAD_WORD        = 32'hFFFF_FFFF;
    localparam logic [3:0]        HEADER_TAG      = 4'hA;
    localparam logic [WORD_W-1:0] SAMPLE_RSV_MASK = 32'hC000_C000;
    localparam logic [CFG_W-1:0]  WORDS_RESET     = 19'd256;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic [PAIR_W-1:0] pair_index;
        logic [SAMP_W-1:0] sample_low;
        logic [SAMP_W-1:0] sample_high;
        logic [MASK_W-1:0] pattern;
        logic [MASK_W-1:0] channel_mask;
        logic [CNT_W-1:0]  event_counter;
        logic [WORD_W-1:0] time_tag;
        logic [ERR_W-1:0]  error_code;
        logic              last_of_record;
    } t_result;

endpackage

// File: design/deap_front.sv
// Front end: accepts readout words, tracks the aggregate and classifies each item.
module deap_front #(
    parameter int CHANNEL_COUNT = deap_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_index,
    input  logic [deap_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_accept,
    input  logic [deap_pkg::WORD_W-1:0]  i_word,
    output logic                         o_push,
    output deap_pkg::t_result            o_result
);

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    localparam logic [1:0] HDR_IDLE    = 2'd0;
    localparam logic [1:0] HDR_FLAGS   = 2'd1;
    localparam logic [1:0] HDR_COUNTER = 2'd2;
    localparam logic [1:0] HDR_TIME    = 2'd3;

    typedef enum logic [3:0] {
        PH_WAIT      = 4'b0001,
        PH_AFTER_PAD = 4'b0010,
        PH_HEADER    = 4'b0100,
        PH_DATA      = 4'b1000
    } t_phase;

    t_phase                            r_phase, n_phase;
    logic [1:0]                        r_hdr_idx, n_hdr_idx;
    logic [deap_pkg::SIZE_W-1:0]       r_agg_size, n_agg_size;
    logic [deap_pkg::SIZE_W-1:0]       r_consumed, n_consumed;
    logic [CHANNEL_COUNT-1:0]          r_pending, n_pending;
    logic [CH_W-1:0]                   r_cur, n_cur;
    logic [deap_pkg::PAIR_W-1:0]       r_pair, n_pair;
    logic [deap_pkg::MASK_W-1:0]       r_pattern, n_pattern;
    logic [deap_pkg::MASK_W-1:0]       r_mask, n_mask;
    logic [deap_pkg::CNT_W-1:0]        r_counter, n_counter;
    logic [CHANNEL_COUNT-1:0]          r_enabled;
    logic [deap_pkg::CFG_W-1:0]        r_words;

    logic                              res_valid;
    deap_pkg::t_result                 res;
    logic [CHANNEL_COUNT-1:0]          left_mask;
    logic                              last_pair;

    function automatic logic [CH_W-1:0] lowest_channel(input logic [CHANNEL_COUNT-1:0] m);
        logic [CH_W-1:0] c;
        c = '0;
        for (int k = CHANNEL_COUNT - 1; k >= 0; k--) begin
            if (m[k]) begin
                c = CH_W'(k);
            end
        end
        return c;
    endfunction

    function automatic deap_pkg::t_result error_result(input logic [deap_pkg::ERR_W-1:0] code);
        deap_pkg::t_result e;
        e            = '0;
        e.kind       = deap_pkg::KIND_ERROR;
        e.error_code = code;
        return e;
    endfunction

    assign last_pair = ({1'b0, r_pair} + 20'd1) >= {1'b0, r_words};
    assign left_mask = r_pending & ~(CHANNEL_COUNT'(1) << r_cur);

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_agg_size = r_agg_size;
        n_consumed = r_consumed;
        n_pending  = r_pending;
        n_cur      = r_cur;
        n_pair     = r_pair;
        n_pattern  = r_pattern;
        n_mask     = r_mask;
        n_counter  = r_counter;
        res_valid  = 1'b0;
        res        = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_consumed = r_consumed + 28'd1;
                    unique case (r_hdr_idx)
                        HDR_FLAGS: begin
                            if (i_word[26]) begin
                                res_valid = 1'b1;
                                res       = error_result(deap_pkg::ERR_BOARD_FAIL);
                                n_phase   = PH_WAIT;
                                n_hdr_idx = HDR_IDLE;
                            end else begin
                                n_pattern = i_word[23:8];
                                n_mask    = {8'h00, i_word[7:0]};
                                n_hdr_idx = HDR_COUNTER;
                            end
                        end
                        HDR_COUNTER: begin
                            n_mask    = {i_word[31:24], r_mask[7:0]};
                            n_counter = i_word[23:0];
                            n_hdr_idx = HDR_TIME;
                        end
                        default: begin
                            n_hdr_idx          = HDR_IDLE;
                            n_pending          = r_mask[CHANNEL_COUNT-1:0];
                            res_valid          = 1'b1;
                            res.kind           = deap_pkg::KIND_HEADER;
                            res.pattern        = r_pattern;
                            res.channel_mask   = r_mask;
                            res.event_counter  = r_counter;
                            res.time_tag       = i_word;
                            if (n_pending == '0) begin
                                n_phase = PH_WAIT;
                                if (n_consumed != r_agg_size) begin
                                    res = error_result(deap_pkg::ERR_SIZE);
                                end
                            end else begin
                                n_cur   = lowest_channel(n_pending);
                                n_pair  = '0;
                                n_phase = PH_DATA;
                            end
                        end
                    endcase
                end
                PH_DATA: begin
                    n_consumed = r_consumed + 28'd1;
                    res_valid  = 1'b1;
                    if (r_pair == '0 && !r_enabled[r_cur]) begin
                        res       = error_result(deap_pkg::ERR_DISABLED);
                        n_phase   = PH_WAIT;
                        n_hdr_idx = HDR_IDLE;
                    end else if ((i_word & deap_pkg::SAMPLE_RSV_MASK) != '0) begin
                        res       = error_result(deap_pkg::ERR_BAD_SAMPLE);
                        n_phase   = PH_WAIT;
                        n_hdr_idx = HDR_IDLE;
                    end else begin
                        res.kind           = deap_pkg::KIND_PAIR;
                        res.channel        = deap_pkg::CHAN_W'(r_cur);
                        res.pair_index     = r_pair;
                        res.sample_low     = i_word[13:0];
                        res.sample_high    = i_word[29:16];
                        res.last_of_record = last_pair;
                        if (last_pair) begin
                            n_pending = left_mask;
                            if (left_mask == '0) begin
                                n_phase = PH_WAIT;
                                if (n_consumed != r_agg_size) begin
                                    res       = error_result(deap_pkg::ERR_SIZE);
                                    n_hdr_idx = HDR_IDLE;
                                end
                            end else begin
                                n_cur  = lowest_channel(left_mask);
                                n_pair = '0;
                            end
                        end else begin
                            n_pair = r_pair + 19'd1;
                        end
                    end
                end
                default: begin
                    // one padding word may precede the tag word
                    if (r_phase != PH_AFTER_PAD && i_word == deap_pkg::PAD_WORD) begin
                        n_phase = PH_AFTER_PAD;
                    end else if (i_word[31:28] != deap_pkg::HEADER_TAG) begin
                        res_valid = 1'b1;
                        res       = error_result(deap_pkg::ERR_NO_TAG);
                        n_phase   = PH_WAIT;
                        n_hdr_idx = HDR_IDLE;
                    end else begin
                        n_agg_size = i_word[27:0];
                        n_consumed = 28'd1;
                        n_hdr_idx  = HDR_FLAGS;
                        n_phase    = PH_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_hdr_idx  <= HDR_IDLE;
            r_agg_size <= '0;
            r_consumed <= '0;
            r_pending  <= '0;
            r_cur      <= '0;
            r_pair     <= '0;
            r_pattern  <= '0;
            r_mask     <= '0;
            r_counter  <= '0;
            r_enabled  <= '0;
            r_words    <= deap_pkg::WORDS_RESET;
        end else begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_agg_size <= n_agg_size;
            r_consumed <= n_consumed;
            r_pending  <= n_pending;
            r_cur      <= n_cur;
            r_pair     <= n_pair;
            r_pattern  <= n_pattern;
            r_mask     <= n_mask;
            r_counter  <= n_counter;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    deap_pkg::REG_ENABLED: r_enabled <= i_cfg_data[CHANNEL_COUNT-1:0];
                    deap_pkg::REG_WORDS:   r_words   <= i_cfg_data;
                    default:               r_words   <= r_words;
                endcase
            end
        end
    end

    assign o_push   = res_valid;
    assign o_result = res;

    a_data_has_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_pending != '0)
        else $error("data phase with no channel left");

    a_header_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_hdr_idx != HDR_IDLE)
        else $error("header phase without a header word index");

    a_error_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.kind == deap_pkg::KIND_ERROR |-> o_result.error_code != '0)
        else $error("error item without a code");

    a_wait_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.kind == deap_pkg::KIND_ERROR |=> r_phase == PH_WAIT)
        else $error("parser did not return to waiting after an error");

endmodule

// File: design/deap_queue.sv
// Short result queue between the parser and the output stage.
module deap_queue #(
    parameter int DEPTH = deap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  deap_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_avail,
    output deap_pkg::t_result o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    deap_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_avail = r_count != '0;
    assign o_data  = r_mem[r_rd];

endmodule

// File: design/deap_back.sv
// Output stage: holds one result item and packs it onto the master stream.
module deap_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_avail,
    input  deap_pkg::t_result              i_data,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [deap_pkg::TDATA_W-1:0]   o_tdata,
    output logic [deap_pkg::KIND_W-1:0]    o_tuser,
    output logic                           o_tlast
);

    logic              r_valid;
    deap_pkg::t_result r_item;

    // load whenever the register is empty or its item leaves this cycle
    assign o_pop = i_avail && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_data;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_item.kind;
    assign o_tlast  = r_item.last_of_record;
    assign o_tdata  = {2'b00, r_item.error_code, r_item.time_tag, r_item.event_counter,
                       r_item.channel_mask, r_item.pattern, r_item.sample_high,
                       r_item.sample_low, r_item.pair_index, r_item.channel};

endmodule

// File: design/digitizer_event_aggregate_parser.sv
// Top level of the digitizer event aggregate parser: front end, queue and output stage.
// Throughput: one readout word per cycle while the result queue is not full; each word is parsed as it is taken.
// A result item is written into the queue when its word is taken, then loaded into the output register.
// The slave side stalls only while the result queue is full.
// Reset is synchronous, active low, and holds both ready outputs low: parser waits for a
//   header, queue and output are emptied, enabled_channels 0, words_per_channel 256.
module digitizer_event_aggregate_parser #(
    parameter int CHANNEL_COUNT = deap_pkg::CHANNEL_COUNT_DEF,
    parameter int QUEUE_DEPTH   = deap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [deap_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // word [31:0]
    input  logic [deap_pkg::WORD_W-1:0]    i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // channel [3:0], pair_index [22:4], sample_low [36:23], sample_high [50:37],
    // pattern [66:51], channel_mask [82:67], event_counter [106:83], time_tag [138:107],
    // error_code [141:139], zero [143:142]
    output logic [deap_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    // kind [1:0]
    output logic [deap_pkg::KIND_W-1:0]    o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              avail;
    deap_pkg::t_result front_res;
    deap_pkg::t_result head;

    assign o_cfg_ready     = i_rst_n;
    assign o_s_axis_tready = i_rst_n && !full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    deap_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_word      (i_s_axis_tdata),
        .o_push      (push),
        .o_result    (front_res)
    );

    deap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_data  (head)
    );

    deap_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (avail),
        .i_data   (head),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
